// ===== rtl/mdmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mdmb_pkg;

  // number of view ports on the block
  localparam int PORTS = 4;
  // default number of views taken into account
  localparam int VIEWS_DEFAULT = 4;
  // depth sample width
  localparam int DEPTH_W = 8;
  // width of a rank or a count of valid views (0..PORTS)
  localparam int CNT_W = $clog2(PORTS + 1);

  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // what one lane found for its view
  typedef struct packed {
    logic   valid;
    cnt_t   rank;
    depth_t depth;
  } lane_result_t;

endpackage

`default_nettype wire

// ===== rtl/mdmb_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdmb_lane #(
  parameter int INDEX = 0
) (
  input  wire logic                                     clk,
  input  wire logic                                     en,
  input  wire mdmb_pkg::depth_t [mdmb_pkg::PORTS-1:0]   depth_in,
  input  wire logic [mdmb_pkg::PORTS-1:0]               valid_in,
  output mdmb_pkg::lane_result_t                        result
);
  import mdmb_pkg::*;

  cnt_t rank;

  // stable rank: valid views below this one, ties broken by view order
  always_comb begin
    rank = '0;
    for (int j = 0; j < PORTS; j++) begin
      if (j != INDEX && valid_in[j] &&
          ((depth_in[j] < depth_in[INDEX]) ||
           ((depth_in[j] == depth_in[INDEX]) && (j < INDEX)))) begin
        rank = rank + cnt_t'(1);
      end
    end
  end

  // lane result register
  always_ff @(posedge clk) begin
    if (en) begin
      result.valid <= valid_in[INDEX];
      result.rank  <= rank;
      result.depth <= depth_in[INDEX];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mdmb_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdmb_merge (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          in_valid,
  input  wire mdmb_pkg::lane_result_t [mdmb_pkg::PORTS-1:0]  lanes,
  input  wire mdmb_pkg::cnt_t                                count,
  output mdmb_pkg::depth_t                                   blended_depth,
  output logic                                               blended_valid,
  output logic                                               done
);
  import mdmb_pkg::*;

  cnt_t   half;
  depth_t sel_depth;

  // at most one valid lane holds rank count/2; none gives zero
  always_comb begin
    half      = count >> 1;
    sel_depth = '0;
    for (int i = 0; i < PORTS; i++) begin
      if (lanes[i].valid && (lanes[i].rank == half)) begin
        sel_depth = sel_depth | lanes[i].depth;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_valid) begin
      blended_depth <= sel_depth;
      blended_valid <= (count != '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/masked_depth_median_blend.sv =====
// a transaction is registered in the lanes and stage one, and its result strobes on done from the merge register
// throughput: one transaction per cycle, set by the lane rank compare and the merge select
// busy stays low; the receiver cannot stall, so nothing holds the pipeline
// reset (rst, synchronous) clears the stage strobes; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module masked_depth_median_blend #(
  parameter int VIEWS = mdmb_pkg::VIEWS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire mdmb_pkg::depth_t depth_0,
  input  wire logic             valid_0,
  input  wire mdmb_pkg::depth_t depth_1,
  input  wire logic             valid_1,
  input  wire mdmb_pkg::depth_t depth_2,
  input  wire logic             valid_2,
  input  wire mdmb_pkg::depth_t depth_3,
  input  wire logic             valid_3,
  output mdmb_pkg::depth_t      blended_depth,
  output logic                  blended_valid,
  output logic                  done
);
  import mdmb_pkg::*;

  depth_t [PORTS-1:0]       depth_vec;
  logic   [PORTS-1:0]       valid_raw;
  logic   [PORTS-1:0]       valid_vec;
  cnt_t                     count_now;
  cnt_t                     count;
  logic                     s1_valid;
  logic                     take;
  lane_result_t [PORTS-1:0] lanes;

  assign busy = 1'b0;
  assign take = start && !busy;

  assign depth_vec = {depth_3, depth_2, depth_1, depth_0};
  assign valid_raw = {valid_3, valid_2, valid_1, valid_0};

  // views beyond VIEWS never count as present
  for (genvar i = 0; i < PORTS; i++) begin : g_mask
    assign valid_vec[i] = (i < VIEWS) ? valid_raw[i] : 1'b0;
  end

  // number of present views
  always_comb begin
    count_now = '0;
    for (int i = 0; i < PORTS; i++) begin
      count_now = count_now + CNT_W'(valid_vec[i]);
    end
  end

  // one ranking lane per view
  for (genvar i = 0; i < PORTS; i++) begin : g_lane
    mdmb_lane #(
      .INDEX(i)
    ) u_lane (
      .clk     (clk),
      .en      (take),
      .depth_in(depth_vec),
      .valid_in(valid_vec),
      .result  (lanes[i])
    );
  end

  // stage one strobe and count
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      count <= count_now;
    end
  end

  mdmb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s1_valid),
    .lanes        (lanes),
    .count        (count),
    .blended_depth(blended_depth),
    .blended_valid(blended_valid),
    .done         (done)
  );

  // every accepted transaction gives a result strobe once it has passed the lane and merge registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |=> ##1 done)
    else $error("result strobe missing after accepted transaction");

  // no result without a transaction in stage one
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result strobe without a transaction");

  // an invalid result carries zero depth
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !blended_valid) |-> (blended_depth == '0))
    else $error("null result with nonzero depth");

  // validity follows the stage one count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> (blended_valid == ($past(count) != '0)))
    else $error("result validity does not match view count");

endmodule

`default_nettype wire

// ===== dv/mdmb_scoreboard.sv =====
`timescale 1ns / 1ps

module mdmb_scoreboard #(
  parameter int VIEWS = mdmb_pkg::VIEWS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  mdmb_pkg::depth_t depth_0,
  input  logic             valid_0,
  input  mdmb_pkg::depth_t depth_1,
  input  logic             valid_1,
  input  mdmb_pkg::depth_t depth_2,
  input  logic             valid_2,
  input  mdmb_pkg::depth_t depth_3,
  input  logic             valid_3,
  input  mdmb_pkg::depth_t blended_depth,
  input  logic             blended_valid,
  input  logic             done,
  output int               fail_count,
  output int               open_count
);
  import mdmb_pkg::*;

  // views that take part, clamped to the ports that exist
  localparam int USED_VIEWS = (VIEWS < 0) ? 0 : ((VIEWS > PORTS) ? PORTS : VIEWS);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    depth_t depth;
    logic   valid;
  } blend_t;

  blend_t expected_blends[$];
  int     errors = 0;

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  // upper median of the valid depths, insertion sorted
  function automatic blend_t median_of_views(input logic [PORTS-1:0][DEPTH_W-1:0] depths,
                                             input logic [PORTS-1:0] present);
    depth_t sorted [PORTS];
    int     count;
    int     k;
    blend_t r;
    count = 0;
    for (int v = 0; v < USED_VIEWS; v++) begin
      if (present[v]) begin
        k = count;
        while (k > 0 && sorted[k-1] > depths[v]) begin
          sorted[k] = sorted[k-1];
          k--;
        end
        sorted[k] = depths[v];
        count++;
      end
    end
    if (count == 0) begin
      r.depth = '0;
      r.valid = 1'b0;
    end else begin
      r.depth = sorted[count/2];
      r.valid = 1'b1;
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  // results are checked before new transactions are queued
  always @(posedge clk) begin
    blend_t want;
    if (!rst) begin
      if (done) begin
        if (expected_blends.size() == 0) begin
          note_failure($sformatf("result with nothing pending: depth %0d valid %0b",
                                 blended_depth, blended_valid));
        end else begin
          want = expected_blends.pop_front();
          if (blended_valid !== want.valid)
            note_failure($sformatf("blended_valid expected %0b actual %0b",
                                   want.valid, blended_valid));
          if (blended_depth !== want.depth)
            note_failure($sformatf("blended_depth expected %0d actual %0d",
                                   want.depth, blended_depth));
        end
      end
      // append the prediction for the accepted transaction
      if (start && !busy)
        expected_blends = {expected_blends,
                           median_of_views({depth_3, depth_2, depth_1, depth_0},
                                           {valid_3, valid_2, valid_1, valid_0})};
    end
    fail_count <= errors;
    open_count <= expected_blends.size();
  end

endmodule

// ===== dv/tb_masked_depth_median_blend.sv =====
`timescale 1ns / 1ps

module tb_masked_depth_median_blend;
  import mdmb_pkg::*;

  localparam int VIEWS        = VIEWS_DEFAULT;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  depth_t depth_0 = '0;
  logic   valid_0 = 1'b0;
  depth_t depth_1 = '0;
  logic   valid_1 = 1'b0;
  depth_t depth_2 = '0;
  logic   valid_2 = 1'b0;
  depth_t depth_3 = '0;
  logic   valid_3 = 1'b0;
  logic   busy;
  depth_t blended_depth;
  logic   blended_valid;
  logic   done;
  int     fail_count;
  int     open_count;
  int unsigned cycle_count = 0;

  always #6 clk = ~clk;

  masked_depth_median_blend #(.VIEWS(VIEWS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .depth_0(depth_0), .valid_0(valid_0), .depth_1(depth_1), .valid_1(valid_1),
    .depth_2(depth_2), .valid_2(valid_2), .depth_3(depth_3), .valid_3(valid_3),
    .blended_depth(blended_depth), .blended_valid(blended_valid), .done(done)
  );

  mdmb_scoreboard #(.VIEWS(VIEWS)) u_scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .depth_0(depth_0), .valid_0(valid_0), .depth_1(depth_1), .valid_1(valid_1),
    .depth_2(depth_2), .valid_2(valid_2), .depth_3(depth_3), .valid_3(valid_3),
    .blended_depth(blended_depth), .blended_valid(blended_valid), .done(done),
    .fail_count(fail_count), .open_count(open_count)
  );

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one pixel and hold it until the transaction is taken
  task automatic send_pixel(input logic [PORTS-1:0][DEPTH_W-1:0] depths,
                            input logic [PORTS-1:0] present);
    start   <= 1'b1;
    depth_0 <= depths[0];
    valid_0 <= present[0];
    depth_1 <= depths[1];
    valid_1 <= present[1];
    depth_2 <= depths[2];
    valid_2 <= present[2];
    depth_3 <= depths[3];
    valid_3 <= present[3];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending until every pending result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // extremes and a narrow band so that ties are common
  function automatic depth_t random_depth();
    depth_t d;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = '1;
      2, 3:    d = depth_t'($urandom_range(100, 103));
      default: d = depth_t'($urandom_range(0, 255));
    endcase
    return d;
  endfunction

  initial begin
    logic [PORTS-1:0][DEPTH_W-1:0] pix;
    int burst_left;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no view valid, with and without junk depths
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0}, 4'b0000);
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255}, 4'b0000);
    // one view valid at each position
    send_pixel({8'd9, 8'd9, 8'd9, 8'd255}, 4'b0001);
    send_pixel({8'd9, 8'd9, 8'd0, 8'd9}, 4'b0010);
    send_pixel({8'd9, 8'd128, 8'd9, 8'd9}, 4'b0100);
    send_pixel({8'd77, 8'd9, 8'd9, 8'd9}, 4'b1000);
    // four views, even count picks the upper middle
    send_pixel({8'd40, 8'd30, 8'd20, 8'd10}, 4'b1111);
    send_pixel({8'd10, 8'd20, 8'd30, 8'd40}, 4'b1111);
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255}, 4'b1111);
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0}, 4'b1111);
    send_pixel({8'd9, 8'd5, 8'd9, 8'd5}, 4'b1111);
    send_pixel({8'd0, 8'd255, 8'd0, 8'd255}, 4'b1111);
    // two views
    send_pixel({8'd1, 8'd1, 8'd255, 8'd0}, 4'b0011);
    send_pixel({8'd1, 8'd200, 8'd1, 8'd100}, 4'b0101);
    send_pixel({8'd1, 8'd50, 8'd60, 8'd1}, 4'b0110);
    send_pixel({8'd7, 8'd1, 8'd1, 8'd7}, 4'b1001);
    send_pixel({8'd3, 8'd1, 8'd250, 8'd1}, 4'b1010);
    send_pixel({8'd0, 8'd255, 8'd1, 8'd1}, 4'b1100);
    // three views, an invalid extreme must not count
    send_pixel({8'd255, 8'd30, 8'd10, 8'd20}, 4'b0111);
    send_pixel({8'd30, 8'd0, 8'd10, 8'd20}, 4'b1011);
    send_pixel({8'd30, 8'd10, 8'd255, 8'd20}, 4'b1101);
    send_pixel({8'd30, 8'd10, 8'd20, 8'd0}, 4'b1110);
    send_pixel({8'd4, 8'd4, 8'd4, 8'd4}, 4'b1110);

    // random pixels in bursts with idle gaps between them
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
      end
      pix = {random_depth(), random_depth(), random_depth(), random_depth()};
      send_pixel(pix, 4'($urandom_range(0, 15)));
      burst_left--;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== masked_depth_median_blend.f =====
rtl/mdmb_pkg.sv
rtl/mdmb_lane.sv
rtl/mdmb_merge.sv
rtl/masked_depth_median_blend.sv
dv/mdmb_scoreboard.sv
dv/tb_masked_depth_median_blend.sv
